[src/rse_pkg.sv]
// Package for the reciprocal square root estimate block.
// Holds the base/decrement table and field constants; no dependencies.
`default_nettype none
package rse_pkg;
  localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] PosInf     = 64'h7FF0_0000_0000_0000;
  localparam logic [10:0] ExpAll     = 11'h7FF;
  localparam logic [12:0] ExpSum     = 13'd3068;

  function automatic logic [25:0] rs_base(input logic [4:0] sel);
    logic [25:0] v;
    case (sel)
      5'd0:  v = 26'h1a7e800;  5'd1:  v = 26'h17cb800;
      5'd2:  v = 26'h1552800;  5'd3:  v = 26'h130c000;
      5'd4:  v = 26'h10f2000;  5'd5:  v = 26'h0eff000;
      5'd6:  v = 26'h0d2e000;  5'd7:  v = 26'h0b7c000;
      5'd8:  v = 26'h09e5000;  5'd9:  v = 26'h0867000;
      5'd10: v = 26'h06ff000;  5'd11: v = 26'h05ab800;
      5'd12: v = 26'h046a000;  5'd13: v = 26'h0339800;
      5'd14: v = 26'h0218800;  5'd15: v = 26'h0105800;
      5'd16: v = 26'h3ffa000;  5'd17: v = 26'h3c29000;
      5'd18: v = 26'h38aa000;  5'd19: v = 26'h3572000;
      5'd20: v = 26'h3279000;  5'd21: v = 26'h2fb7000;
      5'd22: v = 26'h2d26000;  5'd23: v = 26'h2ac0000;
      5'd24: v = 26'h2881000;  5'd25: v = 26'h2665000;
      5'd26: v = 26'h2468000;  5'd27: v = 26'h2287000;
      5'd28: v = 26'h20c1000;  5'd29: v = 26'h1f12000;
      5'd30: v = 26'h1d79000;  default: v = 26'h1bf4000;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] rs_dec(input logic [4:0] sel);
    logic [10:0] v;
    case (sel)
      5'd0:  v = 11'h568; 5'd1:  v = 11'h4f3; 5'd2:  v = 11'h48d; 5'd3:  v = 11'h435;
      5'd4:  v = 11'h3e7; 5'd5:  v = 11'h3a2; 5'd6:  v = 11'h365; 5'd7:  v = 11'h32e;
      5'd8:  v = 11'h2fc; 5'd9:  v = 11'h2d0; 5'd10: v = 11'h2a8; 5'd11: v = 11'h283;
      5'd12: v = 11'h261; 5'd13: v = 11'h243; 5'd14: v = 11'h226; 5'd15: v = 11'h20b;
      5'd16: v = 11'h7a4; 5'd17: v = 11'h700; 5'd18: v = 11'h670; 5'd19: v = 11'h5f2;
      5'd20: v = 11'h584; 5'd21: v = 11'h524; 5'd22: v = 11'h4cc; 5'd23: v = 11'h47e;
      5'd24: v = 11'h43a; 5'd25: v = 11'h3fa; 5'd26: v = 11'h3c2; 5'd27: v = 11'h38e;
      5'd28: v = 11'h35e; 5'd29: v = 11'h332; 5'd30: v = 11'h30a; default: v = 11'h2e6;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[src/reciprocal_sqrt_estimate_top.sv]
// Reciprocal square root estimate, top level.
// Depends on rse_pkg (table and constants).
//
//   channel | ports                        | transfer when
//   --------+------------------------------+--------------------------
//   operand | start, busy, operand_bits    | start && !busy
//   result  | done, estimate_bits          | done (one cycle, no stall)
//
// Between start and done lie the operand register, then the result register.
// One transfer per cycle; busy is always low, the receiver cannot stall.
// rst (synchronous) clears the valid bits only; payload is unreset.
`default_nettype none
module reciprocal_sqrt_estimate_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] operand_bits,
  output logic             done,
  output logic [63:0]      estimate_bits
);
  logic        op_valid;
  logic [63:0] op;
  logic [63:0] estimate_next;

  // field split
  logic [51:0] frac;
  logic [10:0] expf;
  logic        neg;
  // normalization
  logic [5:0]  lz;
  logic [51:0] nfrac;
  logic [12:0] e;        // signed-ish: 1 - s may be negative, kept in 13 bits
  logic [12:0] diff;
  logic [15:0] idx;
  logic [25:0] prod;
  logic [25:0] val;

  assign busy = 1'b0;

  always_comb begin
    frac = op[51:0];
    expf = op[62:52];
    neg  = op[63];
    lz = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (frac[i]) lz = 6'(51 - i);
    end
    // denormal: s = lz + 1 shifts bring the leading one to the hidden bit
    nfrac = (expf == 11'd0) ? ((frac << lz) << 1) : frac;
    e     = (expf == 11'd0) ? (13'd0 - 13'(lz)) : {2'b00, expf};
    diff  = rse_pkg::ExpSum - e;
    idx   = {e[0], nfrac[51:37]};
    prod  = {15'd0, rse_pkg::rs_dec(idx[15:11])} * {15'd0, idx[10:0]};
    val   = rse_pkg::rs_base(idx[15:11]) - prod;
    if (expf == 11'd0 && frac == 52'd0) begin
      estimate_next = {neg, rse_pkg::PosInf[62:0]};
    end else if (expf == rse_pkg::ExpAll) begin
      if (frac == 52'd0) estimate_next = neg ? rse_pkg::DefaultNan : 64'd0;
      else estimate_next = op | 64'h0008_0000_0000_0000;
    end else if (neg) begin
      estimate_next = rse_pkg::DefaultNan;
    end else begin
      estimate_next = {1'b0, diff[11:1], val, 26'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      op_valid <= start;
      done     <= op_valid;
    end
    if (start) op <= operand_bits;
    if (op_valid) estimate_bits <= estimate_next;
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    op_valid |=> done) else $error("result strobe lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !op_valid |=> !done) else $error("result without operand");
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    start ##2 1'b1 |-> done || $past(rst, 1)) else $error("latency slip");
endmodule
`default_nettype wire

[tb/sv/rse_checker.sv]
// Scoreboard for the reciprocal square root estimate block.
// Watches operand and result transfers, predicts each estimate; needs only the DUT ports and rse_pkg.
`timescale 1ns / 1ps
module rse_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [63:0] operand_bits,
  input  wire logic        done,
  input  wire logic [63:0] estimate_bits,
  output int               fail_count,
  output int               pending
);
  logic [63:0] estimate_q[$];

  function automatic logic [25:0] base_of(input logic [4:0] sel);
    logic [25:0] tbl [32];
    tbl = '{26'h1a7e800, 26'h17cb800, 26'h1552800, 26'h130c000,
            26'h10f2000, 26'h0eff000, 26'h0d2e000, 26'h0b7c000,
            26'h09e5000, 26'h0867000, 26'h06ff000, 26'h05ab800,
            26'h046a000, 26'h0339800, 26'h0218800, 26'h0105800,
            26'h3ffa000, 26'h3c29000, 26'h38aa000, 26'h3572000,
            26'h3279000, 26'h2fb7000, 26'h2d26000, 26'h2ac0000,
            26'h2881000, 26'h2665000, 26'h2468000, 26'h2287000,
            26'h20c1000, 26'h1f12000, 26'h1d79000, 26'h1bf4000};
    return tbl[sel];
  endfunction

  function automatic logic [10:0] dec_of(input logic [4:0] sel);
    logic [10:0] tbl [32];
    tbl = '{11'h568, 11'h4f3, 11'h48d, 11'h435, 11'h3e7, 11'h3a2, 11'h365, 11'h32e,
            11'h2fc, 11'h2d0, 11'h2a8, 11'h283, 11'h261, 11'h243, 11'h226, 11'h20b,
            11'h7a4, 11'h700, 11'h670, 11'h5f2, 11'h584, 11'h524, 11'h4cc, 11'h47e,
            11'h43a, 11'h3fa, 11'h3c2, 11'h38e, 11'h35e, 11'h332, 11'h30a, 11'h2e6};
    return tbl[sel];
  endfunction

  function automatic logic [63:0] rsqrt_estimate(input logic [63:0] x);
    logic [51:0] frac;
    logic [10:0] expf;
    int          e;
    int          shift;
    logic [10:0] rexp;
    logic [15:0] idx;
    logic [25:0] val;
    frac = x[51:0];
    expf = x[62:52];
    if (expf == 0 && frac == 0) return {x[63], rse_pkg::PosInf[62:0]};
    if (expf == rse_pkg::ExpAll) begin
      if (frac == 0) return x[63] ? rse_pkg::DefaultNan : 64'd0;
      return x | (64'd1 << 51);
    end
    if (x[63]) return rse_pkg::DefaultNan;
    if (expf == 0) begin
      shift = 1;
      while (!frac[51]) begin
        frac = frac << 1;
        shift++;
      end
      frac = frac << 1;
      e = 1 - shift;
    end else begin
      e = expf;
    end
    rexp = 11'((3068 - e) >>> 1);
    idx = {e[0], frac[51:37]};
    val = base_of(idx[15:11]) - ({15'd0, dec_of(idx[15:11])} * {15'd0, idx[10:0]});
    return {1'b0, rexp, val, 26'd0};
  endfunction

  assign pending = estimate_q.size();

  always @(posedge clk) begin
    if (rst) begin
      estimate_q.delete();
      fail_count <= 0;
    end else begin
      if (done) begin
        if (estimate_q.size() == 0) begin
          $error("unexpected result estimate_bits=%h", estimate_bits);
          fail_count <= fail_count + 1;
        end else if (estimate_q[0] !== estimate_bits) begin
          $error("estimate_bits expected %h actual %h", estimate_q[0], estimate_bits);
          fail_count <= fail_count + 1;
          void'(estimate_q.pop_front());
        end else begin
          void'(estimate_q.pop_front());
        end
      end
      if (start && !busy) estimate_q.push_back(rsqrt_estimate(operand_bits));
    end
  end
endmodule

[tb/sv/tb_reciprocal_sqrt_estimate_top.sv]
// Top of the reciprocal square root estimate testbench: clock, reset, stimulus, verdict.
// Depends on reciprocal_sqrt_estimate_top, rse_pkg and rse_checker.
`timescale 1ns / 1ps
module tb_reciprocal_sqrt_estimate_top;
  logic        clk;
  logic        rst;
  logic        start;
  logic [63:0] operand_bits;
  wire         busy;
  wire         done;
  wire  [63:0] estimate_bits;
  int          fail_count;
  int          pending;

  reciprocal_sqrt_estimate_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand_bits(operand_bits), .done(done), .estimate_bits(estimate_bits)
  );

  rse_checker scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand_bits(operand_bits),
    .done(done), .estimate_bits(estimate_bits), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Hard stop: 450 items with worst gaps stay far below this.
  initial begin
    #2_000_000;
    $display("[reciprocal_sqrt_estimate_top] ERROR");
    $finish;
  end

  // Drive one operand from a falling edge and hold it until it is taken.
  // Start stays high when the next transfer follows with no gap.
  task automatic send_operand(input logic [63:0] value);
    operand_bits <= value;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 99) < 60) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      operand_bits <= {$urandom, $urandom};
      repeat (n) @(negedge clk);
    end
  endtask

  // Random double with the class of operand chosen for coverage.
  function automatic logic [63:0] random_operand();
    logic [63:0] x;
    int          kind;
    x = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 55) x[63] = 1'b0;                    // ordinary positive
    else if (kind < 70) begin                       // positive denormal, varied depth
      x[63:52] = 12'h000;
      x[51:0] = x[51:0] >> $urandom_range(0, 51);
      if (x[51:0] == 0) x[0] = 1'b1;
    end else if (kind < 78) x[62:52] = rse_pkg::ExpAll;       // NaN or infinity
    else if (kind < 83) x[62:0] = 63'd0;                      // signed zero
    else if (kind < 88) x[62:0] = {rse_pkg::ExpAll, 52'd0};   // signed infinity
    return x;                                       // otherwise any pattern, negatives too
  endfunction

  logic [63:0] directed [] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
    64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF0_0000_0000_0001, 64'hFFF4_5555_AAAA_1234,
    64'h7FF8_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
    64'h0008_0000_0000_0000, 64'h0000_0000_0000_0003,
    64'h0010_0000_0000_0000, 64'h3FF0_0000_0000_0000,
    64'h4000_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF,
    64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF7_FFE0_0000_0000,
    64'h4007_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555
  };

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operand_bits = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      send_operand(directed[i]);
      idle_gap();
    end

    // Drain once: sender waits for every estimate.
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 450; i++) begin
      send_operand(random_operand());
      if (i > 100 && i < 160) continue;             // a burst with no gaps
      idle_gap();
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0)
      $display("[reciprocal_sqrt_estimate_top] OK");
    else
      $display("[reciprocal_sqrt_estimate_top] ERROR");
    $finish;
  end
endmodule

[reciprocal_sqrt_estimate_top.f]
src/rse_pkg.sv
src/reciprocal_sqrt_estimate_top.sv
tb/sv/rse_checker.sv
tb/sv/tb_reciprocal_sqrt_estimate_top.sv
